[sv/gpc_pkg.sv]
// shared types, constants and helper functions for the grid path counter
// no dependencies
`timescale 1ns / 1ps

package gpc_pkg;

   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 128;
   localparam int COUNT_BITS = 32;
   localparam int DIM_BITS   = 8;
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  sat;
      logic [COUNT_BITS-1:0] count;
   } cell_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                finish;
   } pos_type;

   // last column index in use for a raw register value
   function automatic logic [COL_BITS-1:0] col_last(input logic [DIM_BITS-1:0] v);
      logic [COL_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > MAX_COLS) begin
         r = COL_BITS'(MAX_COLS - 1);
      end else begin
         r = COL_BITS'(v - DIM_BITS'(1));
      end
      return r;
   endfunction

   // last row index in use for a raw register value
   function automatic logic [ROW_BITS-1:0] row_last(input logic [DIM_BITS-1:0] v);
      logic [ROW_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > MAX_ROWS) begin
         r = ROW_BITS'(MAX_ROWS - 1);
      end else begin
         r = ROW_BITS'(v - DIM_BITS'(1));
      end
      return r;
   endfunction

endpackage

[sv/gpc_req_if.sv]
// request channel: one grid cell word with its obstacle bit
// depends on gpc_pkg
`timescale 1ns / 1ps

interface gpc_req_if;
   import gpc_pkg::*;

   logic valid;
   logic ready;
   logic blocked;

   modport source (output valid, output blocked, input ready);
   modport sink (input valid, input blocked, output ready);
endinterface

[sv/gpc_rsp_if.sv]
// response channel: one path count word per cell
// depends on gpc_pkg
`timescale 1ns / 1ps

interface gpc_rsp_if;
   import gpc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] path_count;
   logic                  saturated;
   logic                  finish;

   modport source (output valid, output path_count, output saturated, output finish,
                   input ready);
   modport sink (input valid, input path_count, input saturated, input finish,
                 output ready);
endinterface

[sv/gpc_row_ram.sv]
// row buffer: counts of the previous row, one write and one registered read port
// depends on gpc_pkg
`timescale 1ns / 1ps

module gpc_row_ram
   import gpc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [COL_BITS-1:0] wr_addr,
   input  cell_type            wr_data,
   input  logic                rd_en,
   input  logic [COL_BITS-1:0] rd_addr,
   output cell_type            rd_data
);

   cell_type mem [MAX_COLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gpc_cell_seq.sv]
// grid size registers and row-major position counters
// depends on gpc_pkg
`timescale 1ns / 1ps

module gpc_cell_seq
   import gpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [DIM_BITS-1:0] csr_wdata,
   input  logic                advance,
   output pos_type             pos
);

   logic [DIM_BITS-1:0] rows_ff, rows_in;
   logic [DIM_BITS-1:0] cols_ff, cols_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] cols_last;
   logic [ROW_BITS-1:0] rows_last;

   assign cols_last = col_last(cols_ff);
   assign rows_last = row_last(rows_ff);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_ROWS: rows_in = csr_wdata;
            CSR_GRID_COLS: cols_in = csr_wdata;
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_ff == cols_last) begin
            col_in = '0;
            row_in = (row_ff == rows_last) ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_BITS'(1);
         cols_ff <= DIM_BITS'(1);
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   assign pos.col    = col_ff;
   assign pos.row    = row_ff;
   assign pos.finish = (col_ff == cols_last) && (row_ff == rows_last);

endmodule

[sv/grid_path_count_obstacles.sv]
// top level: grid path counter with obstacles, row buffer datapath and output register
// depends on gpc_pkg, gpc_req_if, gpc_rsp_if, gpc_row_ram, gpc_cell_seq
`timescale 1ns / 1ps

// Takes one grid cell per clock in row-major order and returns its monotone path count
// through the compute stage and an output register; a stalled response holds one cell in the
// compute stage and blocks the request side only when that stage cannot drain. The count
// from the row above comes from a one-port-write, one-port-read row buffer with a registered
// read; a read of the column being written in the same cycle (single-column grids) is
// forwarded. Counts saturate at the all-ones value and raise saturated. Writing either
// size register restarts the grid at the top-left cell; write only while idle.
module grid_path_count_obstacles
   import gpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   gpc_req_if.sink             req_if,
   gpc_rsp_if.source           rsp_if,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [DIM_BITS-1:0] csr_wdata
);

   pos_type  pos;
   logic     req_accept;
   logic     s1_adv;

   logic     s1_valid_ff, s1_valid_in;
   logic     s1_blocked_ff;
   pos_type  s1_pos_ff;
   logic     fwd_valid_ff, fwd_valid_in;
   cell_type fwd_cell_ff;
   cell_type left_ff;
   logic     out_valid_ff, out_valid_in;
   cell_type out_cell_ff;
   logic     out_finish_ff;

   cell_type ram_rdata;
   cell_type up_cell;
   cell_type result;
   logic [COUNT_BITS:0] sum;
   logic [COUNT_BITS-1:0] up_cnt, left_cnt;
   logic     up_sat, left_sat;

   gpc_cell_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_accept),
      .pos       (pos)
   );

   gpc_row_ram u_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_pos_ff.col),
      .wr_data (result),
      .rd_en   (req_accept),
      .rd_addr (pos.col),
      .rd_data (ram_rdata)
   );

   assign s1_adv        = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_adv;
   assign req_accept    = req_if.valid && req_if.ready;

   // compute stage
   assign up_cell  = fwd_valid_ff ? fwd_cell_ff : ram_rdata;
   assign up_cnt   = (s1_pos_ff.row != '0) ? up_cell.count : '0;
   assign up_sat   = (s1_pos_ff.row != '0) && up_cell.sat;
   assign left_cnt = (s1_pos_ff.col != '0) ? left_ff.count : '0;
   assign left_sat = (s1_pos_ff.col != '0) && left_ff.sat;
   assign sum      = {1'b0, up_cnt} + {1'b0, left_cnt};

   always_comb begin
      if (s1_blocked_ff) begin
         result.count = '0;
         result.sat   = 1'b0;
      end else if (s1_pos_ff.row == '0 && s1_pos_ff.col == '0) begin
         result.count = COUNT_BITS'(1);
         result.sat   = 1'b0;
      end else if (sum[COUNT_BITS]) begin
         result.count = COUNT_MAX;
         result.sat   = 1'b1;
      end else begin
         result.count = sum[COUNT_BITS-1:0];
         result.sat   = up_sat || left_sat;
      end
   end

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      fwd_valid_in = req_accept ? (s1_adv && (s1_pos_ff.col == pos.col))
                                : (s1_adv ? 1'b0 : fwd_valid_ff);
      out_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            left_ff <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_blocked_ff <= req_if.blocked;
         s1_pos_ff     <= pos;
         fwd_cell_ff   <= result;
      end
      if (s1_adv) begin
         out_cell_ff   <= result;
         out_finish_ff <= s1_pos_ff.finish;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.path_count = out_cell_ff.count;
   assign rsp_if.saturated  = out_cell_ff.sat;
   assign rsp_if.finish     = out_finish_ff;

`ifndef SYNTHESIS
   // a compute stage word that drains always lands in the output register
   a_drain_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_valid_ff)
      else $error("compute stage drained without output word");

   // forwarded row data only pends for a word held in the compute stage
   a_fwd_owned: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> s1_valid_ff)
      else $error("forward pending with empty compute stage");

   // a saturated word always carries the clipped maximum
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cell_ff.sat) |-> (out_cell_ff.count == COUNT_MAX))
      else $error("saturated word below maximum");
`endif

endmodule

[dv/grid_path_count_obstacles_tb.sv]
// testbench for grid_path_count_obstacles: streams grid cells, predicts every path count word
// depends on gpc_pkg, gpc_req_if, gpc_rsp_if and the grid_path_count_obstacles rtl
`timescale 1ns / 1ps

module grid_path_count_obstacles_tb;
   import gpc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_CELLS = 680;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  sat;
      logic                  fin;
   } path_word_type;

   class path_count_board;
      logic [COUNT_BITS-1:0] above_count [MAX_COLS];
      bit                    above_sat [MAX_COLS];
      logic [COUNT_BITS-1:0] left_count;
      bit                    left_sat;
      int                    col_pos;
      int                    row_pos;
      logic [DIM_BITS-1:0]   rows_reg;
      logic [DIM_BITS-1:0]   cols_reg;
      path_word_type         due_words [$];
      int                    errors;
      int                    words_checked;
      int                    grids_done;
      int                    saturated_words;

      function new();
         foreach (above_count[i]) begin
            above_count[i] = '0;
            above_sat[i] = 1'b0;
         end
         rows_reg = DIM_BITS'(1);
         cols_reg = DIM_BITS'(1);
         errors = 0;
         words_checked = 0;
         grids_done = 0;
         saturated_words = 0;
         restart();
      endfunction

      static function int span(input logic [DIM_BITS-1:0] v, input int limit);
         if (v == 0) return 1;
         if (int'(v) > limit) return limit;
         return int'(v);
      endfunction

      function void restart();
         left_count = '0;
         left_sat = 1'b0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      function void set_reg(input csr_index_type idx, input logic [DIM_BITS-1:0] v);
         if (idx == CSR_GRID_ROWS) rows_reg = v;
         else cols_reg = v;
         restart();
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void note_cell(input logic blk);
         int                    rows;
         int                    cols;
         logic [COUNT_BITS:0]   sum;
         logic [COUNT_BITS-1:0] up_count;
         logic [COUNT_BITS-1:0] left_in;
         logic                  up_sat;
         logic                  left_in_sat;
         path_word_type         word;
         rows = span(rows_reg, MAX_ROWS);
         cols = span(cols_reg, MAX_COLS);
         if (blk) begin
            word.count = '0;
            word.sat = 1'b0;
         end else if (row_pos == 0 && col_pos == 0) begin
            word.count = 1;
            word.sat = 1'b0;
         end else begin
            up_count = (row_pos > 0) ? above_count[col_pos] : '0;
            up_sat = (row_pos > 0) && above_sat[col_pos];
            left_in = (col_pos > 0) ? left_count : '0;
            left_in_sat = (col_pos > 0) && left_sat;
            sum = {1'b0, up_count} + {1'b0, left_in};
            word.sat = up_sat | left_in_sat;
            if (sum[COUNT_BITS]) begin
               word.count = COUNT_MAX;
               word.sat = 1'b1;
            end else begin
               word.count = sum[COUNT_BITS-1:0];
            end
         end
         above_count[col_pos] = word.count;
         above_sat[col_pos] = word.sat;
         left_count = word.count;
         left_sat = word.sat;
         word.fin = (row_pos == rows - 1) && (col_pos == cols - 1);
         due_words.push_back(word);
         if (word.fin) grids_done++;
         if (word.sat) saturated_words++;
         col_pos++;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
         end
      endfunction

      function void check_word(input logic [COUNT_BITS-1:0] count, input logic sat,
                               input logic fin);
         path_word_type want;
         if (due_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("word arrived with nothing outstanding: count %0d sat %0b finish %0b",
                        count, sat, fin);
            return;
         end
         want = due_words.pop_front();
         if (count !== want.count || sat !== want.sat || fin !== want.fin) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at word %0d: expected count %0d sat %0b finish %0b,",
                        words_checked, want.count, want.sat, want.fin,
                        " got count %0d sat %0b finish %0b", count, sat, fin);
         end
         words_checked++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [DIM_BITS-1:0] csr_wdata;

   bit req_steady;
   bit rsp_steady;
   int cells_sent;
   int settings_used;
   int quiet_cycles;

   path_count_board board = new();

   gpc_req_if req_ch ();
   gpc_rsp_if rsp_ch ();

   grid_path_count_obstacles DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_cell(input logic blk);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.blocked <= blk;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_cell(blk);
      cells_sent++;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         req_ch.blocked <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DIM_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // response side back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 2) == 0) hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_word(rsp_ch.path_count, rsp_ch.saturated, rsp_ch.finish);
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no word moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int i;
      int n;
      int phase;
      int kind;
      int odds;
      int r_val;
      int c_val;
      int swap;
      int total;
      int random_start;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.blocked <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= '0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      cells_sent = 0;
      settings_used = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // power-on grid is a single cell, every word finishes a grid
      send_cell(1'b0);
      send_cell(1'b1);
      send_cell(1'b0);
      drain_results();

      write_reg(CSR_GRID_ROWS, DIM_BITS'(2));
      write_reg(CSR_GRID_COLS, DIM_BITS'(3));
      settings_used++;
      for (i = 0; i < 6; i++) send_cell(1'b0);
      // blocked start cell, then a blocked inner cell
      send_cell(1'b1);
      for (i = 0; i < 5; i++) send_cell(i == 3);
      send_cell(1'b0);
      send_cell(1'b0);
      drain_results();

      // restart in mid grid, zero width acts as one column
      write_reg(CSR_GRID_COLS, DIM_BITS'(0));
      settings_used++;
      send_cell(1'b0);
      send_cell(1'b0);
      drain_results();

      // oversize width clips to the widest row
      write_reg(CSR_GRID_ROWS, DIM_BITS'(0));
      write_reg(CSR_GRID_COLS, DIM_BITS'(255));
      settings_used++;
      for (i = 0; i < 4; i++) send_cell(1'b0);
      drain_results();

      random_start = cells_sent;
      for (phase = 0; phase < 8 || cells_sent - random_start < RANDOM_CELLS; phase++) begin
         case (phase)
            2: begin
               // large enough for counts to clip
               r_val = 20;
               c_val = 20;
               odds = 64;
            end
            4: begin
               r_val = $urandom_range(128, 255);
               c_val = 1;
               odds = 8;
            end
            6: begin
               r_val = 2;
               c_val = 128;
               odds = 0;
            end
            default: begin
               kind = $urandom_range(0, 9);
               if (kind < 6) begin
                  r_val = $urandom_range(1, 6);
                  c_val = $urandom_range(1, 6);
               end else if (kind < 8) begin
                  r_val = $urandom_range(0, 16);
                  c_val = $urandom_range(0, 16);
               end else if (kind == 8) begin
                  r_val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(128, 255);
                  c_val = $urandom_range(1, 3);
                  if ($urandom_range(0, 1) == 1) begin
                     swap = r_val;
                     r_val = c_val;
                     c_val = swap;
                  end
               end else begin
                  r_val = $urandom_range(0, 255);
                  c_val = $urandom_range(0, 255);
               end
               case ($urandom_range(0, 3))
                  0: odds = 0;
                  1: odds = 2;
                  2: odds = 4;
                  default: odds = 16;
               endcase
            end
         endcase

         if (DIM_BITS'(r_val) != board.rows_reg || $urandom_range(0, 1) == 1)
            write_reg(CSR_GRID_ROWS, DIM_BITS'(r_val));
         if (DIM_BITS'(c_val) != board.cols_reg || $urandom_range(0, 1) == 1)
            write_reg(CSR_GRID_COLS, DIM_BITS'(c_val));
         settings_used++;

         total = path_count_board::span(DIM_BITS'(r_val), MAX_ROWS)
               * path_count_board::span(DIM_BITS'(c_val), MAX_COLS);
         if (phase == 2 || phase == 4 || phase == 6)
            n = total;
         else if (total > 48)
            n = $urandom_range(16, 48);
         else
            n = total * $urandom_range(1, 3)
              + (($urandom_range(0, 2) == 0) ? $urandom_range(0, total - 1) : 0);

         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         for (i = 0; i < n; i++) begin
            send_cell(odds != 0 && $urandom_range(0, odds - 1) == 0);
            if ((phase == 1 && i == n / 2) || $urandom_range(0, 299) == 0)
               drain_results();
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      $display("%0d cells over %0d grid settings, %0d words checked", cells_sent,
               settings_used, board.words_checked);
      $display("%0d grids finished, %0d counts saturated, %0d mismatches", board.grids_done,
               board.saturated_words, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         if (board.pending() != 0) $display("%0d words never arrived", board.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
